// ----- src/reference_frame_diff_stats_defines.svh -----
// Assertion macros used by the reference frame difference statistics RTL (rfds_accum).
`ifndef REFERENCE_FRAME_DIFF_STATS_DEFINES_SVH
`define REFERENCE_FRAME_DIFF_STATS_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RFDS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rfds assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define RFDS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rfds assertion failed");

`endif

// ----- src/rfds_pkg.sv -----
// Package: constants and types of the reference frame difference statistics block.
package rfds_pkg;

	localparam int FRAME_PIXELS = 3990;
	localparam int POS_W = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;

	localparam logic KIND_REF = 1'b0;
	localparam logic KIND_CMP = 1'b1;

	localparam logic [7:0]  MIN_INIT    = 8'hff;
	localparam logic [11:0] CHANGED_MAX = 12'hfff;
	localparam logic [19:0] TOTAL_MAX   = 20'hfffff;

	typedef logic [POS_W-1:0] pos_t;

	typedef struct packed {
		logic       first;
		logic       last;
		logic       kind;
		logic [7:0] pixel;
	} stage_t;

endpackage

// ----- src/rfds_ifs.sv -----
// Interfaces: pixel input channel and statistics result channel.
interface rfds_pix_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] pixel;

	modport source(output valid, func, pixel, input ready);
	modport sink(input valid, func, pixel, output ready);
endinterface

interface rfds_stat_if;
	logic        valid;
	logic        ready;
	logic        frame_kind;
	logic [7:0]  min_value;
	logic [7:0]  max_value;
	logic [8:0]  unique_count;
	logic [11:0] changed_count;
	logic [19:0] delta_sum;
	logic [7:0]  max_delta;

	modport source(output valid, frame_kind, min_value, max_value, unique_count,
		changed_count, delta_sum, max_delta, input ready);
	modport sink(input valid, frame_kind, min_value, max_value, unique_count,
		changed_count, delta_sum, max_delta, output ready);
endinterface

// ----- src/rfds_front.sv -----
// Front end: frame position and kind tracking, reference store, input stage register.
module rfds_front (
	input  logic             clk,
	input  logic             arst_n,
	rfds_pix_if.sink         pix,
	input  logic             take,
	output logic             valid_s1,
	output rfds_pkg::stage_t stage_s1,
	output logic [7:0]       ref_pixel_s1
);
	import rfds_pkg::*;

	localparam pos_t POS_LAST = POS_W'(FRAME_PIXELS - 1);

	logic [7:0] ref_mem [FRAME_PIXELS];

	pos_t pos_q;
	logic kind_q;
	logic accept;
	logic first;
	logic last;
	logic kind_cur;

	assign pix.ready = !valid_s1 || take;
	assign accept    = pix.valid && pix.ready;
	assign first     = (pos_q == '0);
	assign last      = (pos_q == POS_LAST);
	assign kind_cur  = first ? pix.func : kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			kind_q   <= KIND_REF;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				pos_q  <= last ? '0 : pos_q + 1'b1;
				kind_q <= kind_cur;
			end
			if (accept)
				valid_s1 <= 1'b1;
			else if (take)
				valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stage_s1.first <= first;
			stage_s1.last  <= last;
			stage_s1.kind  <= kind_cur;
			stage_s1.pixel <= pix.pixel;
		end
	end

	// reference store: written on reference beats, read on every beat
	always_ff @(posedge clk) begin
		if (accept) begin
			if (kind_cur == KIND_REF)
				ref_mem[pos_q] <= pix.pixel;
			ref_pixel_s1 <= ref_mem[pos_q];
		end
	end

endmodule

// ----- src/rfds_accum.sv -----
// Statistics accumulators and result output register.
`include "reference_frame_diff_stats_defines.svh"

module rfds_accum (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s1,
	input  rfds_pkg::stage_t stage_s1,
	input  logic [7:0]       ref_pixel_s1,
	output logic             take,
	rfds_stat_if.source      stats
);
	import rfds_pkg::*;

	logic [7:0]   run_min_q;
	logic [7:0]   run_max_q;
	logic [8:0]   run_unique_q;
	logic [11:0]  run_changed_q;
	logic [19:0]  run_total_q;
	logic [7:0]   run_maxdelta_q;
	logic [255:0] seen_q;

	logic [7:0]   base_min;
	logic [7:0]   base_max;
	logic [8:0]   base_unique;
	logic [11:0]  base_changed;
	logic [19:0]  base_total;
	logic [7:0]   base_maxdelta;
	logic [255:0] base_seen;

	logic [7:0]   nxt_min;
	logic [7:0]   nxt_max;
	logic [8:0]   nxt_unique;
	logic [11:0]  nxt_changed;
	logic [19:0]  nxt_total;
	logic [7:0]   nxt_maxdelta;
	logic [255:0] nxt_seen;

	logic [7:0]   delta;
	logic [20:0]  total_sum;
	logic         out_valid_q;
	logic         load_out;

	assign take     = valid_s1 && !(stage_s1.last && out_valid_q && !stats.ready);
	assign load_out = take && stage_s1.last;

	assign delta = (ref_pixel_s1 > stage_s1.pixel) ? ref_pixel_s1 - stage_s1.pixel
	                                               : stage_s1.pixel - ref_pixel_s1;
	assign total_sum = {1'b0, base_total} + 21'(delta);

	always_comb begin
		base_min      = stage_s1.first ? MIN_INIT : run_min_q;
		base_max      = stage_s1.first ? 8'd0 : run_max_q;
		base_unique   = stage_s1.first ? 9'd0 : run_unique_q;
		base_changed  = stage_s1.first ? 12'd0 : run_changed_q;
		base_total    = stage_s1.first ? 20'd0 : run_total_q;
		base_maxdelta = stage_s1.first ? 8'd0 : run_maxdelta_q;
		base_seen     = (stage_s1.first && stage_s1.kind == KIND_REF) ? '0 : seen_q;

		nxt_min      = base_min;
		nxt_max      = base_max;
		nxt_unique   = base_unique;
		nxt_changed  = base_changed;
		nxt_total    = base_total;
		nxt_maxdelta = base_maxdelta;
		nxt_seen     = base_seen;

		if (stage_s1.kind == KIND_REF) begin
			nxt_seen = base_seen | (256'd1 << stage_s1.pixel);
			if (!base_seen[stage_s1.pixel])
				nxt_unique = base_unique + 9'd1;
			if (stage_s1.pixel < base_min)
				nxt_min = stage_s1.pixel;
			if (stage_s1.pixel > base_max)
				nxt_max = stage_s1.pixel;
		end else begin
			if (delta != 8'd0 && base_changed != CHANGED_MAX)
				nxt_changed = base_changed + 12'd1;
			nxt_total = total_sum[20] ? TOTAL_MAX : total_sum[19:0];
			if (delta > base_maxdelta)
				nxt_maxdelta = delta;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_min_q      <= MIN_INIT;
			run_max_q      <= '0;
			run_unique_q   <= '0;
			run_changed_q  <= '0;
			run_total_q    <= '0;
			run_maxdelta_q <= '0;
			seen_q         <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (take) begin
				run_min_q      <= nxt_min;
				run_max_q      <= nxt_max;
				run_unique_q   <= nxt_unique;
				run_changed_q  <= nxt_changed;
				run_total_q    <= nxt_total;
				run_maxdelta_q <= nxt_maxdelta;
				seen_q         <= nxt_seen;
			end
			if (load_out)
				out_valid_q <= 1'b1;
			else if (stats.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			stats.frame_kind <= stage_s1.kind;
			if (stage_s1.kind == KIND_REF) begin
				stats.min_value     <= nxt_min;
				stats.max_value     <= nxt_max;
				stats.unique_count  <= nxt_unique;
				stats.changed_count <= '0;
				stats.delta_sum     <= '0;
				stats.max_delta     <= '0;
			end else begin
				stats.min_value     <= '0;
				stats.max_value     <= '0;
				stats.unique_count  <= '0;
				stats.changed_count <= nxt_changed;
				stats.delta_sum     <= nxt_total;
				stats.max_delta     <= nxt_maxdelta;
			end
		end
	end

	assign stats.valid = out_valid_q;

	`RFDS_ASSERT_NOW(a_hold_last_on_full, valid_s1 && stage_s1.last && out_valid_q && !stats.ready, !take)
	`RFDS_ASSERT_NEXT(a_last_gives_result, load_out, out_valid_q)
	`RFDS_ASSERT_NOW(a_ref_result_sane, out_valid_q && stats.frame_kind == KIND_REF, (stats.min_value <= stats.max_value) && (stats.unique_count != 9'd0))
	`RFDS_ASSERT_NOW(a_cmp_result_sane, out_valid_q && stats.frame_kind == KIND_CMP, ((stats.max_delta == 8'd0) == (stats.changed_count == 12'd0)) && (stats.delta_sum >= 20'(stats.changed_count)))

endmodule

// ----- src/reference_frame_diff_stats.sv -----
// A frame's result is loaded into the output register when its last pixel is taken.
// Throughput: one pixel per cycle; stalls only while a result waits and the next ends a frame.
// Result rate is set by the single output register; the reference store has one port pair.
// Reset: arst_n clears position, frame kind, running statistics, seen map and output valid.
// Reset does not clear the reference store; compare frames need a prior reference frame.
module reference_frame_diff_stats (
	input  logic        clk,
	input  logic        arst_n,
	rfds_pix_if.sink    pix,
	rfds_stat_if.source stats
);
	import rfds_pkg::*;

	logic       take;
	logic       valid_s1;
	stage_t     stage_s1;
	logic [7:0] ref_pixel_s1;

	rfds_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.pix          (pix),
		.take         (take),
		.valid_s1     (valid_s1),
		.stage_s1     (stage_s1),
		.ref_pixel_s1 (ref_pixel_s1)
	);

	rfds_accum u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.stage_s1     (stage_s1),
		.ref_pixel_s1 (ref_pixel_s1),
		.take         (take),
		.stats        (stats)
	);

endmodule
